// File: hdl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [2:0] KeyBytes = 3'd4;
  localparam logic [7:0] OpcodeMask = 8'h0f;

  // One classified beat on its way from the parser to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       masked;
    logic       last;
    logic       empty;
  } wsfd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wsfd_qstat_t;

endpackage

// File: hdl/websocket_frame_deframer_core.sv
// WebSocket frame deframer: decodes a received RFC 6455 byte stream into payload beats.
// The block takes one received byte per cycle while in_stall_o is low and gives at
// most one beat per cycle. Header bytes (two, plus two or eight extended length bytes,
// plus four mask key bytes when masked) give no beat; each payload byte gives one
// unmasked beat, and a frame of zero length gives one beat flagged empty. A byte enters
// the parser, its beat is written into a QueueDepth-entry queue and from there loaded
// into the output register. in_stall_o rises only while the queue is full, which
// happens only when the output side stalls.
module websocket_frame_deframer_core
  import wsfd_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [3:0] frame_opcode_o,
  output logic       was_masked_o,
  output logic       last_of_frame_o,
  output logic       empty_frame_o
);

  wsfd_entry_t push_entry, pop_entry;
  wsfd_qstat_t qstat;
  logic        accept, push, pop;

  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !qstat.full;

  wsfd_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .rx_byte_i(rx_byte_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  wsfd_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_entry),
    .pop_i  (pop),
    .rdata_o(pop_entry),
    .stat_o (qstat)
  );

  wsfd_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (pop_entry),
    .stat_i         (qstat),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .payload_byte_o (payload_byte_o),
    .frame_opcode_o (frame_opcode_o),
    .was_masked_o   (was_masked_o),
    .last_of_frame_o(last_of_frame_o),
    .empty_frame_o  (empty_frame_o)
  );

endmodule

// File: hdl/wsfd_parse.sv
// Header parser: accepts received bytes and classifies each payload beat.
module wsfd_parse
  import wsfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  output logic        push_o,
  output wsfd_entry_t entry_o
);

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExtLen,
    PhMask,
    PhData
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [31:0] key_q, key_d;
  logic [2:0]  key_left_q, key_left_d;
  logic [63:0] remain_q, remain_d;
  logic [1:0]  pos_q, pos_d;
  logic [7:0]  key_byte;

  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    logic hdr_done;
    logic len_done;
    hdr_done   = 1'b0;
    len_done   = 1'b0;
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    masked_d   = masked_q;
    len_left_d = len_left_q;
    key_d      = key_q;
    key_left_d = key_left_q;
    remain_d   = remain_q;
    pos_d      = pos_q;
    push_o     = 1'b0;
    entry_o    = '{data: 8'd0, key: 8'd0, opcode: opcode_q, masked: masked_q,
                   last: 1'b1, empty: 1'b1};
    if (accept_i) begin
      case (phase_q)
        PhHdr1: begin
          masked_d = rx_byte_i[7];
          if (rx_byte_i[6:0] == LenCode16) begin
            remain_d   = '0;
            len_left_d = ExtBytes16;
            phase_d    = PhExtLen;
          end else if (rx_byte_i[6:0] == LenCode64) begin
            remain_d   = '0;
            len_left_d = ExtBytes64;
            phase_d    = PhExtLen;
          end else begin
            remain_d = {57'd0, rx_byte_i[6:0]};
            len_done = 1'b1;
          end
        end
        PhExtLen: begin
          remain_d = {remain_q[55:0], rx_byte_i};
          if (len_left_q != 4'd0) begin
            len_left_d = len_left_q - 4'd1;
          end
          len_done = (len_left_d == 4'd0);
        end
        PhMask: begin
          key_d = {key_q[23:0], rx_byte_i};
          if (key_left_q != 3'd0) begin
            key_left_d = key_left_q - 3'd1;
          end
          hdr_done = (key_left_d == 3'd0);
        end
        PhData: begin
          pos_d = pos_q + 2'd1;
          if (remain_q != 64'd0) begin
            remain_d = remain_q - 64'd1;
          end
          push_o        = 1'b1;
          entry_o.data  = rx_byte_i;
          entry_o.key   = masked_q ? key_byte : 8'd0;
          entry_o.last  = (remain_d == 64'd0);
          entry_o.empty = 1'b0;
          if (remain_d == 64'd0) begin
            phase_d = PhHdr0;
          end
        end
        default: begin
          opcode_d = rx_byte_i[3:0] & OpcodeMask[3:0];
          phase_d  = PhHdr1;
        end
      endcase

      if (len_done) begin
        if (masked_d) begin
          key_d      = '0;
          key_left_d = KeyBytes;
          phase_d    = PhMask;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        if (remain_d == 64'd0) begin
          push_o         = 1'b1;
          entry_o.masked = masked_d;
          phase_d        = PhHdr0;
        end else begin
          pos_d   = 2'd0;
          phase_d = PhData;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHdr0;
      opcode_q   <= '0;
      masked_q   <= 1'b0;
      len_left_q <= '0;
      key_q      <= '0;
      key_left_q <= '0;
      remain_q   <= '0;
      pos_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      masked_q   <= masked_d;
      len_left_q <= len_left_d;
      key_q      <= key_d;
      key_left_q <= key_left_d;
      remain_q   <= remain_d;
      pos_q      <= pos_d;
    end
  end

endmodule

// File: hdl/wsfd_fifo.sv
// Short queue of classified beats between the parser and the output stage.
module wsfd_fifo
  import wsfd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  wsfd_entry_t wdata_i,
  input  logic        pop_i,
  output wsfd_entry_t rdata_o,
  output wsfd_qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wsfd_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/wsfd_emit.sv
// Output stage: unmasks queued beats and holds them in the output register.
module wsfd_emit
  import wsfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wsfd_entry_t entry_i,
  input  wsfd_qstat_t stat_i,
  output logic        pop_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [3:0]  frame_opcode_o,
  output logic        was_masked_o,
  output logic        last_of_frame_o,
  output logic        empty_frame_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic [3:0] opcode_q;
  logic       masked_q, last_q, empty_q;

  assign pop_o = !stat_i.empty && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q   <= entry_i.data ^ entry_i.key;
      opcode_q <= entry_i.opcode;
      masked_q <= entry_i.masked;
      last_q   <= entry_i.last;
      empty_q  <= entry_i.empty;
    end
  end

  assign out_valid_o     = valid_q;
  assign payload_byte_o  = byte_q;
  assign frame_opcode_o  = opcode_q;
  assign was_masked_o    = masked_q;
  assign last_of_frame_o = last_q;
  assign empty_frame_o   = empty_q;

endmodule

// File: tb/sv/tb_websocket_frame_deframer_core.sv
// Testbench for the WebSocket frame deframer core with a predicting scoreboard.
module tb_websocket_frame_deframer_core;
  import wsfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned StreamBytes = 1450;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_DATA
  } parse_phase_e;

  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_e;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] opcode;
    logic       masked;
    logic       last;
    logic       empty;
  } deframed_beat_t;

  class frame_scoreboard;
    parse_phase_e   phase = PH_HDR0;
    logic [3:0]     opcode = '0;
    logic           mask_flag = 1'b0;
    logic [3:0]     len_left = '0;
    logic [31:0]    key = '0;
    logic [2:0]     key_left = '0;
    logic [63:0]    remaining = '0;
    logic [1:0]     position = '0;
    deframed_beat_t expected_beats[$];
    int unsigned    mismatches = 0;

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void push_beat(logic [7:0] data, logic last, logic empty);
      deframed_beat_t beat;
      beat.data = data;
      beat.opcode = opcode;
      beat.masked = mask_flag;
      beat.last = last;
      beat.empty = empty;
      expected_beats.push_back(beat);
    endfunction

    function void finish_header();
      if (remaining == 0) begin
        push_beat(8'h00, 1'b1, 1'b1);
        phase = PH_HDR0;
      end else begin
        position = '0;
        phase = PH_DATA;
      end
    endfunction

    function void finish_length();
      if (mask_flag) begin
        key = '0;
        key_left = KeyBytes;
        phase = PH_MASK;
      end else begin
        finish_header();
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [6:0] code;
      logic [7:0] k;
      case (phase)
        PH_HDR1: begin
          code = b[6:0];
          mask_flag = b[7];
          remaining = '0;
          if (code == LenCode16) begin
            len_left = ExtBytes16;
            phase = PH_EXTLEN;
          end else if (code == LenCode64) begin
            len_left = ExtBytes64;
            phase = PH_EXTLEN;
          end else begin
            remaining = 64'(code);
            finish_length();
          end
        end
        PH_EXTLEN: begin
          remaining = {remaining[55:0], b};
          if (len_left != 0) len_left--;
          if (len_left == 0) finish_length();
        end
        PH_MASK: begin
          key = {key[23:0], b};
          if (key_left != 0) key_left--;
          if (key_left == 0) finish_header();
        end
        PH_DATA: begin
          k = mask_flag ? key[8 * (3 - int'(position)) +: 8] : 8'h00;
          position = position + 2'd1;
          if (remaining != 0) remaining--;
          push_beat(b ^ k, remaining == 0, 1'b0);
          if (remaining == 0) phase = PH_HDR0;
        end
        default: begin
          opcode = 4'(b & OpcodeMask);
          phase = PH_HDR1;
        end
      endcase
    endfunction

    task check_beat(input logic [7:0] data, input logic [3:0] op, input logic masked,
                    input logic last, input logic empty);
      deframed_beat_t exp_beat;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat data %02h", data));
      end else begin
        exp_beat = expected_beats.pop_front();
        if (data !== exp_beat.data)
          report($sformatf("payload_byte %02h, expected %02h", data, exp_beat.data));
        if (op !== exp_beat.opcode)
          report($sformatf("frame_opcode %0h, expected %0h", op, exp_beat.opcode));
        if (masked !== exp_beat.masked)
          report($sformatf("was_masked %b, expected %b", masked, exp_beat.masked));
        if (last !== exp_beat.last)
          report($sformatf("last_of_frame %b, expected %b", last, exp_beat.last));
        if (empty !== exp_beat.empty)
          report($sformatf("empty_frame %b, expected %b", empty, exp_beat.empty));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] payload_byte_o;
  logic [3:0] frame_opcode_o;
  logic       was_masked_o;
  logic       last_of_frame_o;
  logic       empty_frame_o;

  frame_scoreboard sb = new;
  int unsigned     cycles = 0;
  int unsigned     sent_bytes = 0;
  bit              send_no_idle = 1'b0;
  bit              recv_no_idle = 1'b0;

  websocket_frame_deframer_core u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .rx_byte_i(rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .payload_byte_o(payload_byte_o),
    .frame_opcode_o(frame_opcode_o),
    .was_masked_o(was_masked_o),
    .last_of_frame_o(last_of_frame_o),
    .empty_frame_o(empty_frame_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_websocket_frame_deframer_core failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the byte is taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = send_no_idle ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] hdr0, input logic masked, input len_form_e form,
                            input logic [63:0] len, input logic [31:0] mkey,
                            input int unsigned n_payload);
    send_byte(hdr0);
    case (form)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_EXT16: begin
        send_byte({masked, LenCode16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LenCode64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) send_byte(mkey[8 * i +: 8]);
    repeat (n_payload) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    logic [63:0] len;
    len_form_e   form;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      form = LEN_SHORT;
      len = 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12));
    end else if (pick < 88) begin
      form = LEN_EXT16;
      len = 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40));
    end else begin
      form = LEN_EXT64;
      len = 64'($urandom_range(0, 20));
    end
    send_no_idle = ($urandom_range(0, 3) == 0);
    send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, len, $urandom,
               int'(len));
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      int unsigned hold;
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) recv_no_idle = !recv_no_idle;
      hold = recv_no_idle ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_beat(payload_byte_o, frame_opcode_o, was_masked_o, last_of_frame_o,
                    empty_frame_o);
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty frames, the extreme opcodes, key byte order and a non-minimal length.
    send_frame(8'h00, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
    send_frame(8'hff, 1'b1, LEN_SHORT, 64'd0, 32'hff00aa55, 0);
    send_frame(8'h81, 1'b1, LEN_SHORT, 64'd3, 32'h01020408, 0);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_frame(8'h72, 1'b0, LEN_EXT16, 64'd1, 32'h0, 0);
    send_byte(8'ha5);
    send_frame(8'h0a, 1'b0, LEN_EXT64, 64'd0, 32'h0, 0);

    while (sent_bytes < StreamBytes) send_random_frame();

    // A 64-bit length with its top bit set never finishes, so it goes last.
    send_no_idle = 1'b0;
    send_frame(8'h09, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0003, $urandom, 6);
    in_valid_i <= 1'b0;

    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("tb_websocket_frame_deframer_core passed");
    end else begin
      $display("tb_websocket_frame_deframer_core failed");
    end
    $finish;
  end

endmodule

// File: websocket_frame_deframer_core.f
hdl/wsfd_pkg.sv
hdl/wsfd_parse.sv
hdl/wsfd_fifo.sv
hdl/wsfd_emit.sv
hdl/websocket_frame_deframer_core.sv
tb/sv/tb_websocket_frame_deframer_core.sv
